// ----- rtl/rsn_pkg.sv -----
// ----------------------------------------------------------------------------
// rsn_pkg: shared types and constants for the running statistics normalizer
// Word formats, controller/datapath command and status groups, helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package rsn_pkg;

    // serial multiplier operand width and divider width / step counter width
    localparam int MBW  = 34;
    localparam int DIVW = 64;
    localparam int DCW  = 7;

    // configuration register indexes
    localparam logic [1:0] CFG_NORMALIZE = 2'd0;
    localparam logic [1:0] CFG_HISTORY   = 2'd1;
    localparam logic [1:0] CFG_TREND     = 2'd2;

    typedef struct packed {
        logic [3:0]         channel;
        logic signed [31:0] sample_value;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] normalized_value;
        logic signed [31:0] trend_slope;
        logic               trend_valid;
        logic signed [31:0] running_mean;
        logic [30:0]        running_std;
        logic signed [31:0] running_min;
        logic signed [31:0] running_max;
        logic [31:0]        sample_count;
    } t_out_word;

    typedef struct packed {
        logic norm;
        logic hist;
        logic trend;
    } t_cfg;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_READ,
        OP_LATCH,
        OP_WALK,
        OP_NSXY,
        OP_SXSY,
        OP_NSXX,
        OP_SXSX,
        OP_DSLOPE,
        OP_COUNT,
        OP_DMEAN,
        OP_MSQ,
        OP_DVAR,
        OP_SQRT,
        OP_PUSH,
        OP_DZ,
        OP_WB,
        OP_OUT
    } t_op;

    typedef struct packed {
        t_op  op;
        logic start;
        logic load;
    } t_cmd;

    typedef struct packed {
        logic step_done;
        logic oor;
        logic slope_go;
        logic den_pos;
        logic n_one;
        logic norm;
    } t_stat;

    // sign and magnitude to saturated 32-bit two's complement
    function automatic logic [31:0] sat_q32(input logic neg, input logic [63:0] mag);
        logic [31:0] r;
        if (mag[63:31] != '0) begin
            r = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
            r = neg ? (32'd0 - mag[31:0]) : mag[31:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/running_stats_normalizer_trend_top.sv -----
// ----------------------------------------------------------------------------
// running_stats_normalizer_trend_top: per-channel running stats and z-score
// Welford mean/variance, min/max, window least-squares slope and z-score
// for Q16.16 samples on up to CHANNELS channels.
//
//   channel   dir  handshake          word
//   in        in   i_in_valid/o_in_stall    t_in_word (channel, sample)
//   out       out  o_out_valid/i_out_stall  t_out_word (eight result fields)
//   cfg       in   i_cfg_valid/o_cfg_ready  index + 1-bit data
//
// One word at a time. A word passes through the control states, the window
// walk and four short serial multiplies for the slope terms (when a slope
// is taken), up to four 64-step divisions (the shared divider sets the
// pace), one serial multiply and a square root. No clearing pass after
// reset; per-channel valid bits clear at once. A finished word waits in
// S_OUT while the output register still holds the previous one; the input
// stays stalled until the controller is back in S_IDLE.
// ----------------------------------------------------------------------------
`default_nettype none

module running_stats_normalizer_trend_top
    import rsn_pkg::*;
#(
    parameter int CHANNELS    = 16,
    parameter int WINDOW      = 64,
    parameter int MIN_SAMPLES = 10
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_word  i_in,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_word      o_out,
    input  wire logic      i_cfg_valid,
    output logic           o_cfg_ready,
    input  wire logic [1:0] i_cfg_index,
    input  wire logic      i_cfg_data
);

    t_cfg  r_cfg;
    t_cmd  w_cmd;
    t_stat w_stat;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{norm: 1'b1, hist: 1'b1, trend: 1'b1};
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_NORMALIZE: r_cfg.norm  <= i_cfg_data;
                CFG_HISTORY:   r_cfg.hist  <= i_cfg_data;
                CFG_TREND:     r_cfg.trend <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    rsn_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd),
        .o_in_stall (o_in_stall)
    );

    rsn_datapath #(
        .CHANNELS    (CHANNELS),
        .WINDOW      (WINDOW),
        .MIN_SAMPLES (MIN_SAMPLES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg       (r_cfg),
        .i_cmd       (w_cmd),
        .i_out_stall (i_out_stall),
        .o_stat      (w_stat),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

    // an accepted word keeps the input stalled while it is worked on
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input not stalled after accept");

    a_slope_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.trend_valid || o_out.trend_slope == '0))
        else $error("slope nonzero without trend_valid");

    a_min_le_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.sample_count != '0 |->
        o_out.running_min <= o_out.running_max)
        else $error("running_min above running_max");

endmodule

`default_nettype wire

// ----- rtl/rsn_ram.sv -----
// ----------------------------------------------------------------------------
// rsn_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rsn_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                       i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                            o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ----- rtl/rsn_mul.sv -----
// ----------------------------------------------------------------------------
// rsn_mul: serial shift-add multiplier
// 64-bit multiplicand (product mod 2^64) times unsigned multiplier, one bit
// per cycle, stops early once the remaining multiplier bits are zero.
// ----------------------------------------------------------------------------
`default_nettype none

module rsn_mul
    import rsn_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [63:0]      i_mcand,
    input  wire logic [MBW-1:0]   i_mplier,
    output logic                  o_done,
    output logic [63:0]           o_prod
);

    logic           r_busy;
    logic [63:0]    r_acc;
    logic [63:0]    r_mcand;
    logic [MBW-1:0] r_mplier;

    assign o_done = r_busy && (r_mplier == '0);
    assign o_prod = r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (o_done) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc    <= '0;
            r_mcand  <= i_mcand;
            r_mplier <= i_mplier;
        end else if (r_busy && r_mplier != '0) begin
            if (r_mplier[0]) begin
                r_acc <= r_acc + r_mcand;
            end
            r_mcand  <= {r_mcand[62:0], 1'b0};
            r_mplier <= r_mplier >> 1;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/rsn_div.sv -----
// ----------------------------------------------------------------------------
// rsn_div: restoring unsigned divider, one quotient bit per cycle
// 64-bit dividend and divisor, truncating quotient; divisor never zero.
// ----------------------------------------------------------------------------
`default_nettype none

module rsn_div
    import rsn_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [DIVW-1:0]   i_num,
    input  wire logic [DIVW-1:0]   i_den,
    output logic                   o_done,
    output logic [DIVW-1:0]        o_quo
);

    logic            r_busy;
    logic [DCW-1:0]  r_cnt;
    logic [DIVW-1:0] r_rem;
    logic [DIVW-1:0] r_quo;
    logic [DIVW-1:0] r_den;
    logic [DIVW:0]   w_shift;
    logic [DIVW:0]   w_diff;

    assign w_shift = {r_rem, r_quo[DIVW-1]};
    assign w_diff  = w_shift - {1'b0, r_den};
    assign o_done  = r_busy && (r_cnt == '0);
    assign o_quo   = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= DCW'(DIVW);
        end else if (o_done) begin
            r_busy <= 1'b0;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_num;
            r_den <= i_den;
        end else if (r_busy && r_cnt != '0) begin
            if (!w_diff[DIVW]) begin
                r_rem <= w_diff[DIVW-1:0];
                r_quo <= {r_quo[DIVW-2:0], 1'b1};
            end else begin
                r_rem <= w_shift[DIVW-1:0];
                r_quo <= {r_quo[DIVW-2:0], 1'b0};
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/rsn_datapath.sv -----
// ----------------------------------------------------------------------------
// rsn_datapath: statistics, window and arithmetic datapath
// Per-channel record RAM with valid bits, circular window RAM, shared serial
// multiplier, shared divider, square root iteration and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rsn_datapath
    import rsn_pkg::*;
#(
    parameter int CHANNELS    = 16,
    parameter int WINDOW      = 64,
    parameter int MIN_SAMPLES = 10
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_in_word  i_in,
    input  wire t_cfg      i_cfg,
    input  wire t_cmd      i_cmd,
    input  wire logic      i_out_stall,
    output t_stat          o_stat,
    output logic           o_out_valid,
    output t_out_word      o_out
);

    localparam int CHW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int WPW = $clog2(WINDOW);
    localparam int FW  = $clog2(WINDOW + 1);
    localparam int WAW = $clog2(CHANNELS * WINDOW);
    localparam int SW  = 32 + 32 + 64 + 31 + 32 + 32 + FW + WPW;

    // channel record
    logic [CHW-1:0]      r_ch;
    logic                r_oor;
    logic signed [31:0]  r_x;
    logic [31:0]         r_cnt;
    logic signed [31:0]  r_mean;
    logic [63:0]         r_sq;
    logic [30:0]         r_std;
    logic signed [31:0]  r_min;
    logic signed [31:0]  r_max;
    logic [FW-1:0]       r_fill;
    logic [WPW-1:0]      r_head;
    logic [CHANNELS-1:0] r_ch_valid;

    // slope sums and results
    logic [FW-1:0]       r_wi;
    logic [WPW-1:0]      r_wi_d;
    logic                r_rd_v;
    logic [63:0]         r_sx;
    logic [63:0]         r_sxx;
    logic signed [63:0]  r_sy;
    logic signed [63:0]  r_sxy;
    logic [63:0]         r_p1;
    logic [63:0]         r_num;
    logic [63:0]         r_den;
    logic [31:0]         r_slope;
    logic                r_tvalid;
    logic [31:0]         r_z;
    logic signed [32:0]  r_d1;

    // square root
    logic [63:0]         r_sq_v;
    logic [63:0]         r_sq_res;
    logic [63:0]         r_sq_bit;

    logic                r_out_v;
    t_out_word           r_out;

    // RAM ports
    logic [SW-1:0]       w_st_rd;
    logic [SW-1:0]       w_st_rec;
    logic [SW-1:0]       w_st_wr;
    logic                w_st_we;
    logic signed [31:0]  w_win_rd;
    logic                w_win_we;
    logic [WAW-1:0]      w_waddr;
    logic [WPW+1:0]      w_off;
    logic [WPW+1:0]      w_psum;
    logic [WPW-1:0]      w_phys;
    logic [WPW+1:0]      w_hsum;
    logic [WPW-1:0]      w_head_inc;
    logic                w_full;

    // arithmetic
    logic                w_mul_start;
    logic [63:0]         w_mcand;
    logic [MBW-1:0]      w_mplier;
    logic                w_mul_done;
    logic [63:0]         w_prod;
    logic                w_div_start;
    logic [63:0]         w_dnum;
    logic [63:0]         w_dden;
    logic                w_div_done;
    logic [63:0]         w_quo;
    logic [32:0]         w_mag_d1;
    logic signed [32:0]  w_d2;
    logic [32:0]         w_mag_d2;
    logic [63:0]         w_num_mag;
    logic [63:0]         w_pdiff;
    logic signed [33:0]  w_q34;
    logic signed [33:0]  w_mean_new;
    logic [64:0]         w_sq_sum;
    logic [63:0]         w_rb;
    logic signed [WPW+32:0] w_iy;
    logic [2*WPW-1:0]    w_ii;
    logic [30:0]         w_sd;
    logic                w_out_free;
    logic                w_walk_done;
    logic                w_sqrt_done;
    logic                w_first;

    assign w_first = i_cmd.start;

    // --- channel record RAM ---
    assign w_st_rec = r_ch_valid[r_ch] ? w_st_rd : '0;
    assign w_st_wr  = {r_cnt, r_mean, r_sq, r_std, r_min, r_max, r_fill, r_head};
    assign w_st_we  = (i_cmd.op == OP_WB);

    rsn_ram #(.WIDTH(SW), .DEPTH(CHANNELS)) u_stat_ram (
        .i_clk   (i_clk),
        .i_we    (w_st_we),
        .i_waddr (r_ch),
        .i_wdata (w_st_wr),
        .i_raddr (r_ch),
        .o_rdata (w_st_rd)
    );

    // --- window RAM, circular per channel ---
    assign w_full = (r_fill == FW'(WINDOW));
    always_comb begin
        w_off = '0;
        if (i_cmd.op == OP_WALK) begin
            w_off = (WPW+2)'(r_wi);
        end else if (!w_full) begin
            w_off = (WPW+2)'(r_fill);
        end
    end
    assign w_psum     = (WPW+2)'(r_head) + w_off;
    assign w_phys     = (w_psum >= (WPW+2)'(WINDOW)) ?
                        WPW'(w_psum - (WPW+2)'(WINDOW)) : WPW'(w_psum);
    assign w_hsum     = (WPW+2)'(r_head) + (WPW+2)'(1);
    assign w_head_inc = (w_hsum >= (WPW+2)'(WINDOW)) ? '0 : WPW'(w_hsum);
    assign w_waddr    = WAW'(r_ch) * WAW'(WINDOW) + WAW'(w_phys);
    assign w_win_we   = (i_cmd.op == OP_PUSH) && i_cfg.hist;

    rsn_ram #(.WIDTH(32), .DEPTH(CHANNELS * WINDOW)) u_win_ram (
        .i_clk   (i_clk),
        .i_we    (w_win_we),
        .i_waddr (w_waddr),
        .i_wdata (r_x),
        .i_raddr (w_waddr),
        .o_rdata (w_win_rd)
    );

    // --- shared units ---
    assign w_mag_d1  = r_d1[32] ? 33'(-r_d1) : 33'(r_d1);
    assign w_d2      = 33'(r_x) - 33'(r_mean);
    assign w_mag_d2  = w_d2[32] ? 33'(-w_d2) : 33'(w_d2);
    assign w_num_mag = r_num[63] ? (64'd0 - r_num) : r_num;
    assign w_sd      = (r_std == '0) ? 31'd1 : r_std;

    always_comb begin
        w_mcand  = '0;
        w_mplier = '0;
        case (i_cmd.op)
            OP_NSXY: begin
                w_mcand  = r_sxy;
                w_mplier = MBW'(r_fill);
            end
            OP_SXSY: begin
                w_mcand  = r_sy;
                w_mplier = r_sx[MBW-1:0];
            end
            OP_NSXX: begin
                w_mcand  = r_sxx;
                w_mplier = MBW'(r_fill);
            end
            OP_SXSX: begin
                w_mcand  = r_sx;
                w_mplier = r_sx[MBW-1:0];
            end
            OP_MSQ: begin
                w_mcand  = 64'(w_mag_d1);
                w_mplier = MBW'(w_mag_d2);
            end
            default: begin
                w_mcand  = '0;
                w_mplier = '0;
            end
        endcase
    end

    always_comb begin
        w_dnum = '0;
        w_dden = 64'd1;
        case (i_cmd.op)
            OP_DSLOPE: begin
                w_dnum = w_num_mag;
                w_dden = r_den;
            end
            OP_DMEAN: begin
                w_dnum = 64'(w_mag_d1);
                w_dden = 64'(r_cnt);
            end
            OP_DVAR: begin
                w_dnum = r_sq;
                w_dden = 64'(r_cnt - 32'd1);
            end
            OP_DZ: begin
                w_dnum = 64'({w_mag_d2, 16'h0000});
                w_dden = 64'(w_sd);
            end
            default: begin
                w_dnum = '0;
                w_dden = 64'd1;
            end
        endcase
    end

    assign w_mul_start = w_first && (i_cmd.op == OP_NSXY || i_cmd.op == OP_SXSY ||
                         i_cmd.op == OP_NSXX || i_cmd.op == OP_SXSX || i_cmd.op == OP_MSQ);
    assign w_div_start = w_first && (i_cmd.op == OP_DSLOPE || i_cmd.op == OP_DMEAN ||
                         i_cmd.op == OP_DVAR || i_cmd.op == OP_DZ);

    rsn_mul u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_mul_start),
        .i_mcand  (w_mcand),
        .i_mplier (w_mplier),
        .o_done   (w_mul_done),
        .o_prod   (w_prod)
    );

    rsn_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_dnum),
        .i_den   (w_dden),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    assign w_pdiff    = r_p1 - w_prod;
    assign w_q34      = $signed({1'b0, w_quo[32:0]});
    assign w_mean_new = 34'(r_mean) + (r_d1[32] ? -w_q34 : w_q34);
    assign w_sq_sum   = {1'b0, r_sq} + {1'b0, w_prod};
    assign w_rb       = r_sq_res + r_sq_bit;
    assign w_iy       = $signed({1'b0, r_wi_d}) * w_win_rd;
    assign w_ii       = r_wi_d * r_wi_d;

    assign w_out_free  = !r_out_v || !i_out_stall;
    assign w_walk_done = !w_first && (r_wi == r_fill) && !r_rd_v;
    assign w_sqrt_done = !w_first && (r_sq_bit == '0);

    // --- status to controller ---
    always_comb begin
        o_stat.oor      = r_oor;
        o_stat.slope_go = i_cfg.trend && (32'(r_fill) >= 32'(MIN_SAMPLES)) &&
                          (r_fill >= FW'(2));
        o_stat.den_pos  = !w_pdiff[63] && (w_pdiff != '0);
        o_stat.n_one    = (r_cnt == '0);
        o_stat.norm     = i_cfg.norm;
        case (i_cmd.op)
            OP_NSXY, OP_SXSY, OP_NSXX, OP_SXSX, OP_MSQ: o_stat.step_done = w_mul_done;
            OP_DSLOPE, OP_DMEAN, OP_DVAR, OP_DZ:      o_stat.step_done = w_div_done;
            OP_SQRT:                                   o_stat.step_done = w_sqrt_done;
            OP_WALK:                                   o_stat.step_done = w_walk_done;
            OP_OUT:                                    o_stat.step_done = w_out_free;
            default:                                   o_stat.step_done = 1'b1;
        endcase
    end

    // --- control registers ---
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ch_valid <= '0;
            r_out_v    <= 1'b0;
            r_rd_v     <= 1'b0;
        end else begin
            if (i_cmd.op == OP_WB) begin
                r_ch_valid[r_ch] <= 1'b1;
            end
            if (i_cmd.op == OP_OUT && w_out_free) begin
                r_out_v <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_v <= 1'b0;
            end
            r_rd_v <= (i_cmd.op == OP_WALK) && !w_first && (r_wi != r_fill);
        end
    end

    // --- payload registers ---
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ch  <= CHW'(i_in.channel);
            r_oor <= (32'(i_in.channel) >= 32'(CHANNELS));
            r_x   <= i_in.sample_value;
        end

        case (i_cmd.op)
            OP_LATCH: begin
                {r_cnt, r_mean, r_sq, r_std, r_min, r_max, r_fill, r_head} <= w_st_rec;
                r_slope  <= '0;
                r_tvalid <= 1'b0;
                r_z      <= r_x;
            end
            OP_WALK: begin
                if (w_first) begin
                    r_wi  <= '0;
                    r_sx  <= '0;
                    r_sxx <= '0;
                    r_sy  <= '0;
                    r_sxy <= '0;
                end else begin
                    if (r_wi != r_fill) begin
                        r_wi   <= r_wi + 1'b1;
                        r_wi_d <= r_wi[WPW-1:0];
                    end
                    if (r_rd_v) begin
                        r_sx  <= r_sx + 64'(r_wi_d);
                        r_sxx <= r_sxx + 64'(w_ii);
                        r_sy  <= r_sy + 64'(w_win_rd);
                        r_sxy <= r_sxy + 64'(w_iy);
                    end
                end
            end
            OP_NSXY, OP_NSXX: begin
                if (w_mul_done) begin
                    r_p1 <= w_prod;
                end
            end
            OP_SXSY: begin
                if (w_mul_done) begin
                    r_num <= w_pdiff;
                end
            end
            OP_SXSX: begin
                if (w_mul_done) begin
                    r_den <= w_pdiff;
                end
            end
            OP_DSLOPE: begin
                if (w_div_done) begin
                    r_slope  <= sat_q32(r_num[63], w_quo);
                    r_tvalid <= 1'b1;
                end
            end
            OP_COUNT: begin
                if (r_cnt != 32'hFFFF_FFFF) begin
                    r_cnt <= r_cnt + 32'd1;
                end
                r_d1 <= 33'(r_x) - 33'(r_mean);
                if (r_cnt == '0) begin
                    // first sample on this channel
                    r_mean <= r_x;
                    r_sq   <= '0;
                    r_min  <= r_x;
                    r_max  <= r_x;
                end else begin
                    if (r_x < r_min) begin
                        r_min <= r_x;
                    end
                    if (r_x > r_max) begin
                        r_max <= r_x;
                    end
                end
            end
            OP_DMEAN: begin
                if (w_div_done) begin
                    r_mean <= w_mean_new[31:0];
                end
            end
            OP_MSQ: begin
                if (w_mul_done) begin
                    r_sq <= w_sq_sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : w_sq_sum[63:0];
                end
            end
            OP_DVAR: begin
                if (w_div_done) begin
                    r_p1 <= w_quo;
                end
            end
            OP_SQRT: begin
                if (w_first) begin
                    r_sq_v   <= r_p1;
                    r_sq_res <= '0;
                    r_sq_bit <= 64'h4000_0000_0000_0000;
                end else if (r_sq_bit != '0) begin
                    if (r_sq_v >= w_rb) begin
                        r_sq_v   <= r_sq_v - w_rb;
                        r_sq_res <= (r_sq_res >> 1) + r_sq_bit;
                    end else begin
                        r_sq_res <= r_sq_res >> 1;
                    end
                    r_sq_bit <= r_sq_bit >> 2;
                end else begin
                    r_std <= (r_sq_res[63:31] != '0) ? 31'h7FFF_FFFF : r_sq_res[30:0];
                end
            end
            OP_PUSH: begin
                if (i_cfg.hist) begin
                    if (w_full) begin
                        r_head <= w_head_inc;
                    end else begin
                        r_fill <= r_fill + 1'b1;
                    end
                end
            end
            OP_DZ: begin
                if (w_div_done) begin
                    r_z <= sat_q32(w_d2[32], w_quo);
                end
            end
            default: begin
            end
        endcase

        if (i_cmd.op == OP_OUT && w_out_free) begin
            if (r_oor) begin
                r_out <= '0;
            end else begin
                r_out.normalized_value <= r_z;
                r_out.trend_slope      <= r_slope;
                r_out.trend_valid      <= r_tvalid;
                r_out.running_mean     <= r_mean;
                r_out.running_std      <= r_std;
                r_out.running_min      <= r_min;
                r_out.running_max      <= r_max;
                r_out.sample_count     <= r_cnt;
            end
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out       = r_out;

endmodule

`default_nettype wire

// ----- rtl/rsn_ctrl.sv -----
// ----------------------------------------------------------------------------
// rsn_ctrl: sequencing state machine
// Steps the datapath through load, slope, Welford update, window push,
// z-score, write-back and output; one word at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module rsn_ctrl
    import rsn_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_valid,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd,
    output logic       o_in_stall
);

    typedef enum logic [18:0] {
        S_IDLE   = 19'b000_0000_0000_0000_0001,
        S_RD     = 19'b000_0000_0000_0000_0010,
        S_LATCH  = 19'b000_0000_0000_0000_0100,
        S_CHECK  = 19'b000_0000_0000_0000_1000,
        S_WALK   = 19'b000_0000_0000_0001_0000,
        S_NSXY   = 19'b000_0000_0000_0010_0000,
        S_SXSY   = 19'b000_0000_0000_0100_0000,
        S_NSXX   = 19'b000_0000_0000_1000_0000,
        S_SXSX   = 19'b000_0000_0001_0000_0000,
        S_DSLOPE = 19'b000_0000_0010_0000_0000,
        S_COUNT  = 19'b000_0000_0100_0000_0000,
        S_DMEAN  = 19'b000_0000_1000_0000_0000,
        S_MSQ    = 19'b000_0001_0000_0000_0000,
        S_DVAR   = 19'b000_0010_0000_0000_0000,
        S_SQRT   = 19'b000_0100_0000_0000_0000,
        S_PUSH   = 19'b000_1000_0000_0000_0000,
        S_DZ     = 19'b001_0000_0000_0000_0000,
        S_WB     = 19'b010_0000_0000_0000_0000,
        S_OUT    = 19'b100_0000_0000_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_first;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (i_in_valid) n_state = S_RD;
            S_RD:     n_state = S_LATCH;
            S_LATCH:  n_state = S_CHECK;
            S_CHECK: begin
                if (i_stat.oor) begin
                    n_state = S_OUT;
                end else if (i_stat.slope_go) begin
                    n_state = S_WALK;
                end else begin
                    n_state = S_COUNT;
                end
            end
            S_WALK:   if (i_stat.step_done) n_state = S_NSXY;
            S_NSXY:   if (i_stat.step_done) n_state = S_SXSY;
            S_SXSY:   if (i_stat.step_done) n_state = S_NSXX;
            S_NSXX:   if (i_stat.step_done) n_state = S_SXSX;
            S_SXSX: begin
                if (i_stat.step_done) begin
                    n_state = i_stat.den_pos ? S_DSLOPE : S_COUNT;
                end
            end
            S_DSLOPE: if (i_stat.step_done) n_state = S_COUNT;
            S_COUNT:  n_state = i_stat.n_one ? S_PUSH : S_DMEAN;
            S_DMEAN:  if (i_stat.step_done) n_state = S_MSQ;
            S_MSQ:    if (i_stat.step_done) n_state = S_DVAR;
            S_DVAR:   if (i_stat.step_done) n_state = S_SQRT;
            S_SQRT:   if (i_stat.step_done) n_state = S_PUSH;
            S_PUSH:   n_state = i_stat.norm ? S_DZ : S_WB;
            S_DZ:     if (i_stat.step_done) n_state = S_WB;
            S_WB:     n_state = S_OUT;
            S_OUT:    if (i_stat.step_done) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_first <= 1'b1;
        end else begin
            r_state <= n_state;
            r_first <= (n_state != r_state);
        end
    end

    always_comb begin
        o_cmd.start = r_first;
        o_cmd.load  = (r_state == S_IDLE) && i_in_valid;
        case (r_state)
            S_RD:     o_cmd.op = OP_READ;
            S_LATCH:  o_cmd.op = OP_LATCH;
            S_WALK:   o_cmd.op = OP_WALK;
            S_NSXY:   o_cmd.op = OP_NSXY;
            S_SXSY:   o_cmd.op = OP_SXSY;
            S_NSXX:   o_cmd.op = OP_NSXX;
            S_SXSX:   o_cmd.op = OP_SXSX;
            S_DSLOPE: o_cmd.op = OP_DSLOPE;
            S_COUNT:  o_cmd.op = OP_COUNT;
            S_DMEAN:  o_cmd.op = OP_DMEAN;
            S_MSQ:    o_cmd.op = OP_MSQ;
            S_DVAR:   o_cmd.op = OP_DVAR;
            S_SQRT:   o_cmd.op = OP_SQRT;
            S_PUSH:   o_cmd.op = OP_PUSH;
            S_DZ:     o_cmd.op = OP_DZ;
            S_WB:     o_cmd.op = OP_WB;
            S_OUT:    o_cmd.op = OP_OUT;
            default:  o_cmd.op = OP_NONE;
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

`default_nettype wire
